/* rtl/core/hse_pkg.sv */
// Shared types, constants and SHA-1 helpers for the HMAC-SHA1 engine.
`default_nettype none
package hse_pkg;

  localparam int CNT_W      = 64;           // key and message byte counters
  localparam int BLK_BYTES  = 64;
  localparam int BLK_W      = 8 * BLK_BYTES;
  localparam int DIG_W      = 160;
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int Q_CW       = $clog2(Q_DEPTH + 1);
  localparam int RND_LAST   = 79;

  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;
  localparam logic [7:0] PAD_FIRST = 8'h80;

  localparam logic [1:0] CMD_KEY = 2'd0;
  localparam logic [1:0] CMD_MSG = 2'd1;
  localparam logic [1:0] CMD_END = 2'd2;

  localparam logic [DIG_W-1:0] SHA_IV =
    {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};

  typedef enum logic [1:0] {OP_KEY, OP_MSG, OP_END} op_t;

  typedef struct packed {
    op_t        kind;
    logic [7:0] data;
    logic       last;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_port_t;

  typedef enum logic [1:0] {PH_IDLE, PH_KEY, PH_MSG} phase_t;
  typedef enum logic [1:0] {FIN_LKEY, FIN_INNER, FIN_OUTER} fin_t;
  typedef enum logic [1:0] {FP_ONE, FP_ZERO, FP_LEN, FP_DONE} fp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_KFEED, ST_KEND, ST_IPAD, ST_MFEED, ST_MEND, ST_FIN,
    ST_OPAD, ST_DFEED, ST_OFIN, ST_OUT, ST_CINIT, ST_COMP, ST_CADD
  } st_t;

  function automatic logic [31:0] sha_f(input logic [6:0] rnd,
                                        input logic [31:0] b,
                                        input logic [31:0] c,
                                        input logic [31:0] d);
    logic [31:0] r;
    if (rnd < 7'd20) begin
      r = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      r = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      r = (b & c) | (b & d) | (c & d);
    end else begin
      r = b ^ c ^ d;
    end
    return r;
  endfunction

  function automatic logic [31:0] sha_k(input logic [6:0] rnd);
    logic [31:0] r;
    if (rnd < 7'd20) begin
      r = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      r = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      r = 32'h8F1BBCDC;
    end else begin
      r = 32'hCA62C1D6;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/hse_front.sv */
// Front end: takes input items, classifies commands and queues them.
`default_nettype none
module hse_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    in_command,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_last,
  output hse_pkg::q_port_t   q_out,
  input  wire logic          q_pop
);

  hse_pkg::q_item_t                 mem_r [hse_pkg::Q_DEPTH];
  logic [hse_pkg::Q_AW-1:0]         wp_r, rp_r;
  logic [hse_pkg::Q_CW-1:0]         cnt_r;
  hse_pkg::q_item_t                 item;
  logic                             keep, push, pop;

  always_comb begin
    item.data = in_data_byte;
    item.last = in_last;
    keep      = 1'b1;
    case (in_command)
      hse_pkg::CMD_KEY: item.kind = hse_pkg::OP_KEY;
      hse_pkg::CMD_MSG: item.kind = hse_pkg::OP_MSG;
      hse_pkg::CMD_END: item.kind = hse_pkg::OP_END;
      default: begin
        item.kind = hse_pkg::OP_KEY;
        keep      = 1'b0;                 // undefined command: dropped
      end
    endcase
  end

  assign in_stall    = (cnt_r == hse_pkg::Q_CW'(hse_pkg::Q_DEPTH));
  assign push        = in_valid && !in_stall && keep;
  assign pop         = q_pop && (cnt_r != '0);
  assign q_out.valid = (cnt_r != '0);
  assign q_out.item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + hse_pkg::Q_CW'(push) - hse_pkg::Q_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= item;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/hse_back.sv */
// Back end: key handling, SHA-1 rounds, padding and result output.
`default_nettype none
module hse_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  hse_pkg::q_port_t       q_in,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [31:0]            out_digest_word,
  output logic                   out_word_last
);

  localparam int BW = hse_pkg::BLK_W;
  localparam int CW = hse_pkg::CNT_W;
  localparam int DW = hse_pkg::DIG_W;

  hse_pkg::st_t    st_r, st_nxt, ret_r, ret_nxt, fafter;
  hse_pkg::phase_t ph_r, ph_nxt;
  hse_pkg::fin_t   fin_r, fin_nxt;
  hse_pkg::fp_t    fp_r, fp_nxt;
  hse_pkg::q_item_t op_r, op_nxt;

  logic [BW-1:0] key_r, key_nxt, blk_r, blk_nxt;
  logic [CW-1:0] kc_r, kc_nxt, mc_r, mc_nxt, bits_r, bits_nxt;
  logic [DW-1:0] hs_r, hs_nxt, dig_r, dig_nxt, v_r, v_nxt;
  logic [6:0]    rnd_r, rnd_nxt;
  logic [2:0]    lcnt_r, lcnt_nxt, wcnt_r, wcnt_nxt;
  logic [4:0]    dcnt_r, dcnt_nxt;
  logic          ov_r, ov_nxt, ol_r, ol_nxt;
  logic [31:0]   ow_r, ow_nxt;

  logic          feed;
  logic [7:0]    fbyte;
  logic [31:0]   a, b, c, d, e, w0, wn, t;
  logic          kc_small, kc_sat;

  assign kc_small = (kc_r[CW-1:6] == '0);
  assign kc_sat   = (kc_r == '1);

  // one round of the compression function
  always_comb begin
    {a, b, c, d, e} = v_r;
    w0 = blk_r[BW-1 -: 32];
    wn = blk_r[BW-1-32*13 -: 32] ^ blk_r[BW-1-32*8 -: 32] ^
         blk_r[BW-1-32*2 -: 32] ^ w0;
    wn = {wn[30:0], wn[31]};
    t  = {a[26:0], a[31:27]} + hse_pkg::sha_f(rnd_r, b, c, d) + e +
         hse_pkg::sha_k(rnd_r) + w0;
  end

  always_comb begin
    st_nxt   = st_r;    ret_nxt  = ret_r;   ph_nxt   = ph_r;
    fin_nxt  = fin_r;   fp_nxt   = fp_r;    op_nxt   = op_r;
    key_nxt  = key_r;   blk_nxt  = blk_r;   kc_nxt   = kc_r;
    mc_nxt   = mc_r;    bits_nxt = bits_r;  hs_nxt   = hs_r;
    dig_nxt  = dig_r;   v_nxt    = v_r;     rnd_nxt  = rnd_r;
    lcnt_nxt = lcnt_r;  wcnt_nxt = wcnt_r;  dcnt_nxt = dcnt_r;
    ow_nxt   = ow_r;    ol_nxt   = ol_r;
    ov_nxt   = ov_r && out_stall;
    q_pop    = 1'b0;
    feed     = 1'b0;
    fbyte    = '0;
    fafter   = hse_pkg::ST_IDLE;

    case (st_r)
      hse_pkg::ST_IDLE: begin
        if (q_in.valid) begin
          q_pop  = 1'b1;
          op_nxt = q_in.item;
          case (q_in.item.kind)
            hse_pkg::OP_KEY: begin
              if (ph_r != hse_pkg::PH_MSG) begin
                ph_nxt = hse_pkg::PH_KEY;
                if (!kc_sat) begin
                  kc_nxt = kc_r + 1'b1;
                end
                if (kc_small) begin
                  for (int i = 0; i < hse_pkg::BLK_BYTES; i++) begin
                    if (kc_r[5:0] == 6'(i)) begin
                      key_nxt[BW-1-8*i -: 8] = q_in.item.data;
                    end
                  end
                  st_nxt = q_in.item.last ? hse_pkg::ST_KEND : hse_pkg::ST_IDLE;
                end else if (kc_r == CW'(hse_pkg::BLK_BYTES)) begin
                  // key overflows one block: start hashing it
                  hs_nxt  = hse_pkg::SHA_IV;
                  blk_nxt = key_r;
                  mc_nxt  = CW'(hse_pkg::BLK_BYTES);
                  ret_nxt = hse_pkg::ST_KFEED;
                  st_nxt  = hse_pkg::ST_CINIT;
                end else begin
                  st_nxt = hse_pkg::ST_KFEED;
                end
              end
            end
            hse_pkg::OP_MSG: begin
              st_nxt = (ph_r != hse_pkg::PH_MSG) ? hse_pkg::ST_KEND : hse_pkg::ST_MFEED;
            end
            hse_pkg::OP_END: begin
              st_nxt = (ph_r != hse_pkg::PH_MSG) ? hse_pkg::ST_KEND : hse_pkg::ST_MEND;
            end
            default: st_nxt = hse_pkg::ST_IDLE;
          endcase
        end
      end
      hse_pkg::ST_KFEED: begin
        feed   = 1'b1;
        fbyte  = op_r.data;
        fafter = op_r.last ? hse_pkg::ST_KEND : hse_pkg::ST_IDLE;
      end
      hse_pkg::ST_KEND: begin
        if (!kc_small && kc_r != CW'(hse_pkg::BLK_BYTES)) begin
          fin_nxt  = hse_pkg::FIN_LKEY;
          fp_nxt   = hse_pkg::FP_ONE;
          bits_nxt = {mc_r[CW-4:0], 3'b000};
          lcnt_nxt = '0;
          st_nxt   = hse_pkg::ST_FIN;
        end else begin
          st_nxt = hse_pkg::ST_IPAD;
        end
      end
      hse_pkg::ST_IPAD: begin
        hs_nxt  = hse_pkg::SHA_IV;
        blk_nxt = key_r ^ {hse_pkg::BLK_BYTES{hse_pkg::IPAD_BYTE}};
        mc_nxt  = CW'(hse_pkg::BLK_BYTES);
        ph_nxt  = hse_pkg::PH_MSG;
        case (op_r.kind)
          hse_pkg::OP_MSG: ret_nxt = hse_pkg::ST_MFEED;
          hse_pkg::OP_END: ret_nxt = hse_pkg::ST_MEND;
          default:         ret_nxt = hse_pkg::ST_IDLE;
        endcase
        st_nxt = hse_pkg::ST_CINIT;
      end
      hse_pkg::ST_MFEED: begin
        feed   = 1'b1;
        fbyte  = op_r.data;
        fafter = op_r.last ? hse_pkg::ST_MEND : hse_pkg::ST_IDLE;
      end
      hse_pkg::ST_MEND: begin
        fin_nxt  = hse_pkg::FIN_INNER;
        fp_nxt   = hse_pkg::FP_ONE;
        bits_nxt = {mc_r[CW-4:0], 3'b000};
        lcnt_nxt = '0;
        st_nxt   = hse_pkg::ST_FIN;
      end
      hse_pkg::ST_FIN: begin
        case (fp_r)
          hse_pkg::FP_ONE: begin
            feed   = 1'b1;
            fbyte  = hse_pkg::PAD_FIRST;
            fafter = hse_pkg::ST_FIN;
            fp_nxt = hse_pkg::FP_ZERO;
          end
          hse_pkg::FP_ZERO: begin
            if (mc_r[5:0] != 6'd56) begin
              feed   = 1'b1;
              fafter = hse_pkg::ST_FIN;
            end else begin
              fp_nxt = hse_pkg::FP_LEN;
            end
          end
          hse_pkg::FP_LEN: begin
            feed     = 1'b1;
            fbyte    = bits_r[CW-1 -: 8];
            fafter   = hse_pkg::ST_FIN;
            bits_nxt = {bits_r[CW-9:0], 8'h00};
            lcnt_nxt = lcnt_r + 1'b1;
            if (lcnt_r == 3'd7) begin
              fp_nxt = hse_pkg::FP_DONE;
            end
          end
          default: begin
            case (fin_r)
              hse_pkg::FIN_LKEY: begin
                key_nxt = {hs_r, {(BW-DW){1'b0}}};
                st_nxt  = hse_pkg::ST_IPAD;
              end
              hse_pkg::FIN_INNER: begin
                dig_nxt = hs_r;
                st_nxt  = hse_pkg::ST_OPAD;
              end
              default: begin
                dig_nxt  = hs_r;
                wcnt_nxt = '0;
                st_nxt   = hse_pkg::ST_OUT;
              end
            endcase
          end
        endcase
      end
      hse_pkg::ST_OPAD: begin
        hs_nxt   = hse_pkg::SHA_IV;
        blk_nxt  = key_r ^ {hse_pkg::BLK_BYTES{hse_pkg::OPAD_BYTE}};
        mc_nxt   = CW'(hse_pkg::BLK_BYTES);
        dcnt_nxt = '0;
        ret_nxt  = hse_pkg::ST_DFEED;
        st_nxt   = hse_pkg::ST_CINIT;
      end
      hse_pkg::ST_DFEED: begin
        feed     = 1'b1;
        fbyte    = dig_r[DW-1 -: 8];
        dig_nxt  = {dig_r[DW-9:0], 8'h00};
        dcnt_nxt = dcnt_r + 1'b1;
        fafter   = (dcnt_r == 5'd19) ? hse_pkg::ST_OFIN : hse_pkg::ST_DFEED;
      end
      hse_pkg::ST_OFIN: begin
        fin_nxt  = hse_pkg::FIN_OUTER;
        fp_nxt   = hse_pkg::FP_ONE;
        bits_nxt = {mc_r[CW-4:0], 3'b000};
        lcnt_nxt = '0;
        st_nxt   = hse_pkg::ST_FIN;
      end
      hse_pkg::ST_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt   = 1'b1;
          ow_nxt   = dig_r[DW-1 -: 32];
          ol_nxt   = (wcnt_r == 3'd4);
          dig_nxt  = {dig_r[DW-33:0], 32'h0};
          wcnt_nxt = wcnt_r + 1'b1;
          if (wcnt_r == 3'd4) begin
            key_nxt = '0;
            kc_nxt  = '0;
            hs_nxt  = hse_pkg::SHA_IV;
            mc_nxt  = '0;
            ph_nxt  = hse_pkg::PH_IDLE;
            st_nxt  = hse_pkg::ST_IDLE;
          end
        end
      end
      hse_pkg::ST_CINIT: begin
        v_nxt   = hs_r;
        rnd_nxt = '0;
        st_nxt  = hse_pkg::ST_COMP;
      end
      hse_pkg::ST_COMP: begin
        v_nxt   = {t, a, {b[1:0], b[31:2]}, c, d};
        blk_nxt = {blk_r[BW-33:0], wn};
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == 7'(hse_pkg::RND_LAST)) begin
          st_nxt = hse_pkg::ST_CADD;
        end
      end
      hse_pkg::ST_CADD: begin
        hs_nxt = {hs_r[159:128] + a, hs_r[127:96] + b, hs_r[95:64] + c,
                  hs_r[63:32] + d, hs_r[31:0] + e};
        st_nxt = ret_r;
      end
      default: st_nxt = hse_pkg::ST_IDLE;
    endcase

    // shared byte path into the block buffer; a full block starts the rounds
    if (feed) begin
      blk_nxt = {blk_r[BW-9:0], fbyte};
      mc_nxt  = mc_r + 1'b1;
      if (mc_r[5:0] == 6'd63) begin
        ret_nxt = fafter;
        st_nxt  = hse_pkg::ST_CINIT;
      end else begin
        st_nxt = fafter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= hse_pkg::ST_IDLE;
      ret_r <= hse_pkg::ST_IDLE;
      ph_r  <= hse_pkg::PH_IDLE;
      fin_r <= hse_pkg::FIN_LKEY;
      fp_r  <= hse_pkg::FP_ONE;
      key_r <= '0;
      kc_r  <= '0;
      mc_r  <= '0;
      hs_r  <= hse_pkg::SHA_IV;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      ret_r <= ret_nxt;
      ph_r  <= ph_nxt;
      fin_r <= fin_nxt;
      fp_r  <= fp_nxt;
      key_r <= key_nxt;
      kc_r  <= kc_nxt;
      mc_r  <= mc_nxt;
      hs_r  <= hs_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    blk_r  <= blk_nxt;
    bits_r <= bits_nxt;
    dig_r  <= dig_nxt;
    v_r    <= v_nxt;
    rnd_r  <= rnd_nxt;
    lcnt_r <= lcnt_nxt;
    wcnt_r <= wcnt_nxt;
    dcnt_r <= dcnt_nxt;
    ow_r   <= ow_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_valid       = ov_r;
  assign out_digest_word = ow_r;
  assign out_word_last   = ol_r;

endmodule
`default_nettype wire

/* rtl/core/hmac_sha1_engine_unit.sv */
// Top level of the HMAC-SHA1 engine: front queue plus SHA-1 back end.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_command, in_data_byte, in_last
//   out_     output     out_valid / out_stall out_digest_word, out_word_last
//
// Message bytes and key bytes past the first 64 are popped, then fed into the
// block buffer; the first 64 key bytes are stored as they are popped. Each full
// 64-byte block is hashed by a load, 80 rounds and a final add. A MAC close feeds
// 73 to 136 padding and digest bytes, at most one per cycle and none while a
// block is hashed, hashes 3 or 4 blocks (more when it also ends the key), then
// offers 5 result items. Reset (rst_n low, synchronous) clears key, counters and
// queue; the 2-item input queue fills, then stalls while out_stall holds a result.
`default_nettype none
module hmac_sha1_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic             out_word_last
);

  hse_pkg::q_port_t q_link;   // head of the item queue
  logic             q_pop;

  // front: command classification and the queue
  hse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .q_out        (q_link),
    .q_pop        (q_pop)
  );

  // back: key handling, SHA-1 rounds, padding, output register
  hse_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_in            (q_link),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_last   (out_word_last)
  );

endmodule
`default_nettype wire

/* rtl/core/hse_checker.sv */
// Port-level checker for the HMAC-SHA1 engine and its bind.
`default_nettype none
module hse_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_command,
  input wire logic [7:0]  in_data_byte,
  input wire logic        in_last,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_digest_word,
  input wire logic        out_word_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word) &&
    $stable(out_word_last))
    else $error("stalled result item changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall after reset");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_word_last |=> !out_valid)
    else $error("result item right after final digest word");

  a_stall_needs_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stalled with no item taken");

endmodule

bind hmac_sha1_engine_unit hse_checker u_hse_checker (.*);
`default_nettype wire
